### rtl/abp_pkg.sv
package abp_pkg;

    localparam int LEVEL_W    = 16;
    localparam int SPEED_W    = 16;
    localparam int RATE_W     = 17;
    localparam int WAIT_W     = 32;
    localparam int RATE_FRAC  = 16;
    localparam int UNIT_SHIFT = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int PROD_W     = SPEED_W + LEVEL_W;
    localparam int STEP_W     = SPEED_W + RATE_W;
    localparam int DIVIDEND_W = WAIT_W + UNIT_SHIFT;
    localparam int DIVISOR_W  = LEVEL_W + 1;
    localparam int DIV_STEPS  = DIVIDEND_W / 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_UP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_DOWN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_WAIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_GOAL = 3'd5;

    localparam logic [SPEED_W-1:0] MIN_SPEED_RST  = 16'd256;
    localparam logic [SPEED_W-1:0] MAX_SPEED_RST  = 16'd1024;
    localparam logic [RATE_W-1:0]  RAMP_UP_RST    = 17'd16384;
    localparam logic [RATE_W-1:0]  RAMP_DOWN_RST  = 17'd6554;
    localparam logic [WAIT_W-1:0]  BASE_WAIT_RST  = 32'd16666667;
    localparam logic [LEVEL_W-1:0] DEPTH_GOAL_RST = 16'd0;
    localparam logic [SPEED_W-1:0] UNIT_SPEED     = 16'd256;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV1_GO,
        ST_DIV1_RUN,
        ST_DESIRE,
        ST_STEP_MUL,
        ST_STEP_UPD,
        ST_DIV2_GO,
        ST_DIV2_RUN,
        ST_DONE
    } abp_state_t;

    typedef struct packed {
        logic load_level;
        logic mul_backlog;
        logic div_start;
        logic div_sel;
        logic take_desired;
        logic mul_step;
        logic upd_speed;
        logic load_out;
    } abp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic div_done;
    } abp_stat_t;

endpackage

### rtl/abp_if.sv
interface abp_in_if;
    logic                         valid;
    logic                         ready;
    logic [abp_pkg::LEVEL_W-1:0]  queue_level;

    modport source (output valid, output queue_level, input ready);
    modport sink   (input valid, input queue_level, output ready);
endinterface

interface abp_out_if;
    logic                         valid;
    logic                         ready;
    logic [abp_pkg::WAIT_W-1:0]   wait_ns;
    logic [abp_pkg::SPEED_W-1:0]  speed_now;

    modport source (output valid, output wait_ns, output speed_now, input ready);
    modport sink   (input valid, input wait_ns, input speed_now, output ready);
endinterface

### rtl/abp_div.sv
module abp_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [abp_pkg::DIVIDEND_W-1:0]  dividend,
    input  logic [abp_pkg::DIVISOR_W-1:0]   divisor,
    output logic                            busy,
    output logic                            done,
    output logic [abp_pkg::DIVIDEND_W-1:0]  quotient
);
    import abp_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    s1, s2;

    function automatic logic [DIVISOR_W:0] div_bit(
        input logic [DIVISOR_W-1:0] r,
        input logic                 b,
        input logic [DIVISOR_W-1:0] d
    );
        logic [DIVISOR_W:0] t;
        logic [DIVISOR_W:0] diff;
        t    = {r, b};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d})
        begin
            div_bit = {1'b1, diff[DIVISOR_W-1:0]};
        end
        else
        begin
            div_bit = {1'b0, t[DIVISOR_W-1:0]};
        end
    endfunction

    // two quotient bits per cycle
    always_comb
    begin
        s1 = div_bit(rem_reg, quo_reg[DIVIDEND_W-1], dsr_reg);
        s2 = div_bit(s1[DIVISOR_W-1:0], quo_reg[DIVIDEND_W-2], dsr_reg);
    end

    always_comb
    begin
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start && !busy_reg)
        begin
            rem_next  = '0;
            dsr_next  = divisor;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = s2[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-3:0], s1[DIVISOR_W], s2[DIVISOR_W]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/abp_datapath.sv
module abp_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [abp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [abp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic [abp_pkg::LEVEL_W-1:0]     queue_level,
    input  abp_pkg::abp_cmd_t               cmd,
    output abp_pkg::abp_stat_t              stat,
    output logic [abp_pkg::WAIT_W-1:0]      wait_ns,
    output logic [abp_pkg::SPEED_W-1:0]     speed_now
);
    import abp_pkg::*;

    localparam int SUM_W  = DIVIDEND_W + 1;
    localparam int NEXT_W = SPEED_W + 3;

    logic [SPEED_W-1:0]    min_speed_reg, max_speed_reg;
    logic [RATE_W-1:0]     ramp_up_reg, ramp_down_reg;
    logic [WAIT_W-1:0]     base_wait_reg;
    logic [LEVEL_W-1:0]    depth_goal_reg;
    logic [SPEED_W-1:0]    speed_mult_reg, speed_mult_next;

    logic [LEVEL_W-1:0]    level_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [SPEED_W-1:0]    desired_reg, desired_next;
    logic [RATE_W-1:0]     rate_reg;
    logic [STEP_W-1:0]     step_prod_reg;
    logic                  neg_reg;
    logic [WAIT_W-1:0]     wait_reg;
    logic [SPEED_W-1:0]    speed_out_reg;

    logic                  over;
    logic [LEVEL_W-1:0]    backlog;
    logic [DIVIDEND_W-1:0] div_dividend, div_quotient;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic                  div_busy, div_done;
    logic [SUM_W-1:0]      sum;
    logic                  gap_neg;
    logic [SPEED_W-1:0]    gap_mag;
    logic [RATE_W-1:0]     step;
    logic signed [NEXT_W-1:0] next_raw, next_lo, next_hi;
    logic [WAIT_W-1:0]     wait_sat;

    assign over    = level_reg > depth_goal_reg;
    assign backlog = level_reg - depth_goal_reg;

    always_comb
    begin
        if (cmd.div_sel)
        begin
            div_dividend = {base_wait_reg, UNIT_SHIFT'(0)};
            div_divisor  = {1'b0, speed_mult_reg};
        end
        else
        begin
            div_dividend = DIVIDEND_W'(prod_reg);
            div_divisor  = {1'b0, depth_goal_reg} + DIVISOR_W'(1);
        end
    end

    abp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign stat.div_busy = div_busy;
    assign stat.div_done = div_done;

    always_comb
    begin
        sum = SUM_W'(min_speed_reg) + SUM_W'(div_quotient);
        if (!over)
        begin
            desired_next = min_speed_reg;
        end
        else if (sum > SUM_W'(max_speed_reg))
        begin
            desired_next = max_speed_reg;
        end
        else
        begin
            desired_next = sum[SPEED_W-1:0];
        end
    end

    assign gap_neg = desired_reg < speed_mult_reg;
    assign gap_mag = gap_neg ? (speed_mult_reg - desired_reg) : (desired_reg - speed_mult_reg);
    assign step    = step_prod_reg[STEP_W-1:RATE_FRAC];

    // clamp to min first, then to max
    always_comb
    begin
        if (neg_reg)
        begin
            next_raw = $signed(NEXT_W'(speed_mult_reg)) - $signed(NEXT_W'(step));
        end
        else
        begin
            next_raw = $signed(NEXT_W'(speed_mult_reg)) + $signed(NEXT_W'(step));
        end
        if (next_raw < $signed(NEXT_W'(min_speed_reg)))
        begin
            next_lo = $signed(NEXT_W'(min_speed_reg));
        end
        else
        begin
            next_lo = next_raw;
        end
        if (next_lo > $signed(NEXT_W'(max_speed_reg)))
        begin
            next_hi = $signed(NEXT_W'(max_speed_reg));
        end
        else
        begin
            next_hi = next_lo;
        end
        speed_mult_next = next_hi[SPEED_W-1:0];
    end

    assign wait_sat = (|div_quotient[DIVIDEND_W-1:WAIT_W]) ? '1 : div_quotient[WAIT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_speed_reg  <= MIN_SPEED_RST;
            max_speed_reg  <= MAX_SPEED_RST;
            ramp_up_reg    <= RAMP_UP_RST;
            ramp_down_reg  <= RAMP_DOWN_RST;
            base_wait_reg  <= BASE_WAIT_RST;
            depth_goal_reg <= DEPTH_GOAL_RST;
            speed_mult_reg <= UNIT_SPEED;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MIN_SPEED:  min_speed_reg  <= cfg_wdata[SPEED_W-1:0];
                    CFG_MAX_SPEED:  max_speed_reg  <= cfg_wdata[SPEED_W-1:0];
                    CFG_RAMP_UP:    ramp_up_reg    <= cfg_wdata[RATE_W-1:0];
                    CFG_RAMP_DOWN:  ramp_down_reg  <= cfg_wdata[RATE_W-1:0];
                    CFG_BASE_WAIT:  base_wait_reg  <= cfg_wdata[WAIT_W-1:0];
                    CFG_DEPTH_GOAL: depth_goal_reg <= cfg_wdata[LEVEL_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.upd_speed)
            begin
                speed_mult_reg <= speed_mult_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_level)
        begin
            level_reg <= queue_level;
        end
        if (cmd.mul_backlog)
        begin
            prod_reg <= min_speed_reg * backlog;
        end
        if (cmd.take_desired)
        begin
            desired_reg <= desired_next;
            rate_reg    <= over ? ramp_up_reg : ramp_down_reg;
        end
        if (cmd.mul_step)
        begin
            step_prod_reg <= gap_mag * rate_reg;
            neg_reg       <= gap_neg;
        end
        if (cmd.load_out)
        begin
            wait_reg      <= wait_sat;
            speed_out_reg <= speed_mult_reg;
        end
    end

    assign wait_ns   = wait_reg;
    assign speed_now = speed_out_reg;

endmodule

### rtl/abp_ctrl.sv
module abp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  abp_pkg::abp_stat_t  stat,
    output abp_pkg::abp_cmd_t   cmd
);
    import abp_pkg::*;

    abp_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_MUL;
            ST_MUL:      state_next = ST_DIV1_GO;
            ST_DIV1_GO:  state_next = ST_DIV1_RUN;
            ST_DIV1_RUN: if (stat.div_done) state_next = ST_DESIRE;
            ST_DESIRE:   state_next = ST_STEP_MUL;
            ST_STEP_MUL: state_next = ST_STEP_UPD;
            ST_STEP_UPD: state_next = ST_DIV2_GO;
            ST_DIV2_GO:  state_next = ST_DIV2_RUN;
            ST_DIV2_RUN: if (stat.div_done) state_next = ST_DONE;
            ST_DONE:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.load_level = in_valid;
            end
            ST_MUL:      cmd.mul_backlog = 1'b1;
            ST_DIV1_GO:  cmd.div_start = 1'b1;
            ST_DIV1_RUN: cmd.div_sel = 1'b0;
            ST_DESIRE:   cmd.take_desired = 1'b1;
            ST_STEP_MUL: cmd.mul_step = 1'b1;
            ST_STEP_UPD: cmd.upd_speed = 1'b1;
            ST_DIV2_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
            end
            ST_DIV2_RUN: cmd.div_sel = 1'b1;
            ST_DONE:     cmd.load_out = out_free;
            default:     cmd = '0;
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_idle_no_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !stat.div_busy)
        else $error("divider busy while idle");

    a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |-> (state_reg == ST_DIV1_RUN || state_reg == ST_DIV2_RUN))
        else $error("division finished outside a run state");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("result load lost");

endmodule

### rtl/adaptive_backlog_pacer_core.sv
// A result is loaded into the output register after its second division finishes and that register is free.
// Requests are handled one at a time: the shared radix-4 divider runs two divisions per
//   request, with control steps around them, before the next request can be taken.
// A finished result waits in the output register; the next request is taken meanwhile.
// Reset (rst_n, async, active low): control state and configuration registers return to defaults, speed to 1.0.
module adaptive_backlog_pacer_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [abp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [abp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    abp_in_if.sink                          in_ch,
    abp_out_if.source                       out_ch
);
    import abp_pkg::*;

    abp_cmd_t  cmd;
    abp_stat_t stat;

    abp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    abp_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .queue_level (in_ch.queue_level),
        .cmd         (cmd),
        .stat        (stat),
        .wait_ns     (out_ch.wait_ns),
        .speed_now   (out_ch.speed_now)
    );

endmodule
